// ===== design/midpoint_line_rasterizer_top_assert.svh =====
// Assertion macros for the midpoint line rasterizer.
`ifndef MIDPOINT_LINE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_TOP_ASSERT_SVH

// Checks that cond holds in the same cycle as trig.
`define MLR_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Checks that cond holds in the cycle after trig.
`define MLR_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== design/mlr_pkg.sv =====
`default_nettype none

package mlr_pkg;

    localparam int COORD_BITS_DEF = 11;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

`default_nettype wire

// ===== design/midpoint_line_rasterizer_top.sv =====
// Midpoint line rasterizer.
// The input stream carries commands. A start transaction (tuser = 0) loads two
// endpoints from tdata and always yields the first pixel of the line. A step
// transaction (tuser = 1) yields the next pixel while a line is active and
// yields nothing when no line is active. Both endpoints are drawn, and the
// pixel at the final endpoint leaves with tlast set.
// Each accepted command is worked out in the cycle it is accepted; its pixel
// is held in the output register from the next cycle on, and one command can
// be taken in every cycle, one pixel per clock, while the receiver keeps up.
// That rate is set by the step loop, one add of the decision term and one
// compare against the endpoint per cycle.
// A result waiting in the output register does not block input as long as
// the receiver takes it in the same cycle; when the receiver stalls, the
// pixel is held and s_axis_tready stays low until it is taken.
// Reset clears the output valid flag and leaves no line active.
`default_nettype none

module midpoint_line_rasterizer_top
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,  // start_x, start_y, end_x, end_y
    input  wire logic             s_axis_tuser,  // command
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,  // pixel_x, pixel_y
    output logic                  m_axis_tlast
);

    localparam int N     = COORD_BITS;
    localparam int INC_W = COORD_BITS + 3;
    localparam int DEC_W = COORD_BITS + 4;

    logic [N-1:0]            cur_x_reg, cur_x_next;
    logic [N-1:0]            cur_y_reg, cur_y_next;
    logic [N-1:0]            stop_x_reg, stop_x_next;
    logic [N-1:0]            stop_y_reg, stop_y_next;
    logic signed [DEC_W-1:0] decision_reg, decision_next;
    logic signed [INC_W-1:0] inc_straight_reg, inc_straight_next;
    logic signed [INC_W-1:0] inc_diagonal_reg, inc_diagonal_next;
    logic                    steep_reg, steep_next;
    logic                    y_down_reg, y_down_next;
    logic                    active_reg, active_next;

    logic                    out_valid_reg;
    logic [N-1:0]            out_x_reg;
    logic [N-1:0]            out_y_reg;
    logic                    out_last_reg;

    logic                    in_fire;
    logic                    produce;
    logic                    last_next;

    logic [N-1:0]            sx, sy, ex, ey;
    logic [N-1:0]            fx, fy, tx, ty;
    logic [N-1:0]            dx, dy, major, minor;
    logic                    st_y_down, st_steep;
    logic [N-1:0]            y_stepped;
    logic [N-1:0]            x_stepped;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign sx = s_axis_tdata[N-1:0];
    assign sy = s_axis_tdata[2*N-1:N];
    assign ex = s_axis_tdata[3*N-1:2*N];
    assign ey = s_axis_tdata[4*N-1:3*N];

    always_comb
    begin
        if (ex > sx)
        begin
            fx = sx;
            fy = sy;
            tx = ex;
            ty = ey;
        end
        else
        begin
            fx = ex;
            fy = ey;
            tx = sx;
            ty = sy;
        end
        dx        = tx - fx;
        st_y_down = ty < fy;
        dy        = st_y_down ? fy - ty : ty - fy;
        st_steep  = dy > dx;
        major     = st_steep ? dy : dx;
        minor     = st_steep ? dx : dy;
    end

    assign y_stepped = y_down_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
    assign x_stepped = cur_x_reg + 1'b1;

    always_comb
    begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        stop_x_next       = stop_x_reg;
        stop_y_next       = stop_y_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        steep_next        = steep_reg;
        y_down_next       = y_down_reg;
        active_next       = active_reg;
        produce           = 1'b0;
        last_next         = 1'b0;
        if (s_axis_tuser == CMD_START)
        begin
            cur_x_next        = fx;
            cur_y_next        = fy;
            stop_x_next       = tx;
            stop_y_next       = ty;
            steep_next        = st_steep;
            y_down_next       = st_y_down;
            decision_next     = $signed(DEC_W'({minor, 1'b0})) - $signed(DEC_W'(major));
            inc_straight_next = $signed(INC_W'({minor, 1'b0}));
            inc_diagonal_next = $signed(INC_W'({minor, 1'b0}))
                              - $signed(INC_W'({major, 1'b0}));
            last_next         = (major == '0);
            active_next       = !last_next;
            produce           = 1'b1;
        end
        else if (active_reg)
        begin
            if (decision_reg > 0)
            begin
                decision_next = decision_reg
                              + {{(DEC_W-INC_W){inc_diagonal_reg[INC_W-1]}}, inc_diagonal_reg};
                if (steep_reg)
                begin
                    cur_x_next = x_stepped;
                end
                else
                begin
                    cur_y_next = y_stepped;
                end
            end
            else
            begin
                decision_next = decision_reg
                              + {{(DEC_W-INC_W){inc_straight_reg[INC_W-1]}}, inc_straight_reg};
            end
            if (steep_reg)
            begin
                cur_y_next = y_stepped;
                last_next  = (y_stepped == stop_y_reg);
            end
            else
            begin
                cur_x_next = x_stepped;
                last_next  = (x_stepped == stop_x_reg);
            end
            active_next = !last_next;
            produce     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            stop_x_reg       <= '0;
            stop_y_reg       <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            steep_reg        <= 1'b0;
            y_down_reg       <= 1'b0;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                cur_x_reg        <= cur_x_next;
                cur_y_reg        <= cur_y_next;
                stop_x_reg       <= stop_x_next;
                stop_y_reg       <= stop_y_next;
                decision_reg     <= decision_next;
                inc_straight_reg <= inc_straight_next;
                inc_diagonal_reg <= inc_diagonal_next;
                steep_reg        <= steep_next;
                y_down_reg       <= y_down_next;
                active_reg       <= active_next;
            end
            if (in_fire && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && produce)
        begin
            out_x_reg    <= cur_x_next;
            out_y_reg    <= cur_y_next;
            out_last_reg <= last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_y_reg, out_x_reg});
    assign m_axis_tlast  = out_last_reg;

`include "midpoint_line_rasterizer_top_assert.svh"

    `MLR_ASSERT_NEXT(a_start_gives_pixel, in_fire && s_axis_tuser == CMD_START,
        m_axis_tvalid, "start transaction produced no pixel")
    `MLR_ASSERT_NEXT(a_step_gives_pixel, in_fire && s_axis_tuser == CMD_STEP && active_reg,
        m_axis_tvalid, "step on an active line produced no pixel")
    `MLR_ASSERT_NEXT(a_last_ends_line, in_fire && produce && last_next,
        !active_reg && m_axis_tlast, "final pixel did not end the line")
    `MLR_ASSERT_SAME(a_active_not_at_end, active_reg,
        (steep_reg ? (cur_y_reg != stop_y_reg) : (cur_x_reg != stop_x_reg)),
        "active line already sits on its final endpoint")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import mlr_pkg::*;

    localparam int CW    = COORD_BITS_DEF;
    localparam int IN_W  = ((4 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + 7) / 8) * 8;
    localparam int DEC_W = CW + 4;
    localparam int INC_W = CW + 3;
    localparam int MAXC  = (1 << CW) - 1;
    localparam int IDLE_LIMIT = 1000;
    localparam int HOLD_CYCLES = 60;

    class line_pixel_tracker;
        typedef struct {
            logic [CW-1:0] x;
            logic [CW-1:0] y;
            logic          last;
        } pixel_t;

        logic [CW-1:0]        cur_x, cur_y, stop_x, stop_y;
        logic signed [CW+3:0] decision;
        logic signed [CW+2:0] inc_straight, inc_diagonal;
        logic                 steep, y_down, active;
        pixel_t               expected_pixels[$];
        int                   errors;

        function new();
            cur_x = '0;
            cur_y = '0;
            stop_x = '0;
            stop_y = '0;
            decision = '0;
            inc_straight = '0;
            inc_diagonal = '0;
            steep = 1'b0;
            y_down = 1'b0;
            active = 1'b0;
            errors = 0;
        endfunction

        function void note_command(logic cmd, logic [CW-1:0] sx, logic [CW-1:0] sy,
                                   logic [CW-1:0] ex, logic [CW-1:0] ey);
            int     dx, dy, major, minor;
            logic   done;
            pixel_t px;
            if (cmd == CMD_START) begin
                if (ex > sx) begin
                    cur_x = sx;
                    cur_y = sy;
                    stop_x = ex;
                    stop_y = ey;
                end
                else begin
                    cur_x = ex;
                    cur_y = ey;
                    stop_x = sx;
                    stop_y = sy;
                end
                dx = int'(stop_x) - int'(cur_x);
                y_down = stop_y < cur_y;
                dy = y_down ? int'(cur_y) - int'(stop_y) : int'(stop_y) - int'(cur_y);
                steep = dy > dx;
                major = steep ? dy : dx;
                minor = steep ? dx : dy;
                decision = DEC_W'(2 * minor - major);
                inc_straight = INC_W'(2 * minor);
                inc_diagonal = INC_W'(2 * (minor - major));
                done = (major == 0);
            end
            else begin
                if (!active)
                    return;
                if (decision > 0) begin
                    decision = decision + inc_diagonal;
                    if (steep)
                        cur_x = cur_x + 1'b1;
                    else
                        cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
                end
                else begin
                    decision = decision + inc_straight;
                end
                if (steep) begin
                    cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
                    done = (cur_y == stop_y);
                end
                else begin
                    cur_x = cur_x + 1'b1;
                    done = (cur_x == stop_x);
                end
            end
            active = !done;
            px.x = cur_x;
            px.y = cur_y;
            px.last = done;
            expected_pixels.insert(expected_pixels.size(), px);
        endfunction

        function void check_pixel(logic [CW-1:0] x, logic [CW-1:0] y, logic last);
            pixel_t px;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d last=%0d", $time, x, y, last);
                errors++;
                return;
            end
            px = expected_pixels.pop_front();
            if (x !== px.x) begin
                $display("%0t: pixel_x expected %0d actual %0d", $time, px.x, x);
                errors++;
            end
            if (y !== px.y) begin
                $display("%0t: pixel_y expected %0d actual %0d", $time, px.y, y);
                errors++;
            end
            if (last !== px.last) begin
                $display("%0t: last expected %0d actual %0d", $time, px.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              s_axis_tuser = CMD_STEP;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;

    line_pixel_tracker tracker = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    logic [7:0] hold_token = '0;
    logic [7:0] hold_seen = '0;

    midpoint_line_rasterizer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // The receiver stalls at random; a new hold token starts a long hold-off.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Input transactions are noted before output transactions are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_command(s_axis_tuser, s_axis_tdata[CW-1:0],
                                     s_axis_tdata[2*CW-1:CW], s_axis_tdata[3*CW-1:2*CW],
                                     s_axis_tdata[4*CW-1:3*CW]);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_pixel(m_axis_tdata[CW-1:0], m_axis_tdata[2*CW-1:CW],
                                    m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_cmd(input logic cmd, input logic [IN_W-1:0] data);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_step();
        logic [63:0]     raw;
        logic [4*CW-1:0] junk;
        raw = {$urandom, $urandom};
        junk = raw[4*CW-1:0];
        send_cmd(CMD_STEP, IN_W'(junk));
    endtask

    task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                             input int steps);
        logic [4*CW-1:0] ends;
        ends = {CW'(ey), CW'(ex), CW'(sy), CW'(sx)};
        send_cmd(CMD_START, IN_W'(ends));
        repeat (steps)
            send_step();
    endtask

    function automatic int near_coord(int base, int span);
        int c;
        c = base + $urandom_range(2 * span) - span;
        if (c < 0)
            c = 0;
        if (c > MAXC)
            c = MAXC;
        return c;
    endfunction

    // Most lines are short and run to their end; some are cut short by a new
    // start, and some get extra steps after the end.
    task automatic random_line();
        int sx, sy, ex, ey, major, steps, kind, r;
        sx = $urandom_range(MAXC);
        sy = $urandom_range(MAXC);
        kind = $urandom_range(99);
        if (kind < 80)
        begin
            ex = near_coord(sx, 12);
            ey = near_coord(sy, 12);
        end
        else if (kind < 95)
        begin
            ex = near_coord(sx, 64);
            ey = near_coord(sy, 64);
        end
        else
        begin
            ex = $urandom_range(MAXC);
            ey = $urandom_range(MAXC);
        end
        major = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > major)
            major = (ey > sy) ? ey - sy : sy - ey;
        steps = major;
        r = $urandom_range(99);
        if (r < 12 && major > 1)
            steps = $urandom_range(major - 1);
        else if (r < 24)
            steps = major + $urandom_range(1, 3);
        if (steps > 80)
            steps = $urandom_range(10, 80);
        send_line(sx, sy, ex, ey, steps);
    endtask

    initial
    begin
        int target;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_step();
        send_line(0, 0, 0, 0, 1);
        send_line(MAXC, MAXC, MAXC, MAXC, 0);
        send_line(MAXC, MAXC, MAXC - 2, MAXC, 2);
        send_line(5, 0, 5, 2, 2);
        send_line(0, 0, 1, 3, 3);
        send_line(MAXC, 0, MAXC - 4, 2, 4);
        send_line(0, 0, MAXC, MAXC, 2);
        send_line(0, MAXC, MAXC, 0, 1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            if (phase == 0 || phase == 2)
                hold_token <= hold_token + 1'b1;
            target = items_sent + 185;
            while (items_sent < target)
                random_line();
        end

        s_axis_tvalid <= 1'b0;
        while (tracker.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
